### design/compaction_dedupe_run_splitter_top_macros.svh
// Assertion helpers for the asserting top-level file of the block.
`ifndef COMPACTION_DEDUPE_RUN_SPLITTER_TOP_MACROS_SVH
`define COMPACTION_DEDUPE_RUN_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdrs assertion failed");

// Next-cycle implication, checked outside reset.
`define CDRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdrs assertion failed");

`endif

### design/cdrs_pkg.sv
`default_nettype none
package cdrs_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned StampW  = 32;
  localparam int unsigned OffsetW = 32;
  localparam int unsigned SizeW   = 17;
  localparam int unsigned SourceW = 16;
  localparam int unsigned BytesW  = 32;

  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 136;
  localparam int unsigned OutUserW = 2;

  // Input tdata layout: key, stamp, offset, size, source.
  localparam int unsigned InKeyLsb    = 0;
  localparam int unsigned InStampLsb  = InKeyLsb + KeyW;
  localparam int unsigned InOffsetLsb = InStampLsb + StampW;
  localparam int unsigned InSizeLsb   = InOffsetLsb + OffsetW;
  localparam int unsigned InSourceLsb = InSizeLsb + SizeW;
  localparam int unsigned InUsedW     = InSourceLsb + SourceW;

  localparam int unsigned OutUsedW = KeyW + OffsetW + SizeW + SourceW;

  localparam logic [BytesW-1:0] RESET_RUN_LIMIT = 32'd2097152;

  // One emit request from the classifier to the run splitter.
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [OffsetW-1:0] offset;
    logic [SizeW-1:0]   size;
    logic [SourceW-1:0] source;
    logic               entry_valid;
    logic               last;
  } cdrs_req_t;

  typedef struct packed {
    logic      valid;
    cdrs_req_t req;
  } cdrs_push_t;

endpackage
`default_nettype wire

### design/compaction_dedupe_run_splitter_top.sv
`default_nettype none
// Compaction dedupe and run splitter. Feed a key-sorted stream of index
// entries on the slave side; each run of equal keys collapses to the entry
// with the strictly greatest stamp (first seen wins a tie), and that survivor
// leaves on the master side when its key group closes, unless it is a
// tombstone. Value sizes of emitted entries add up in a saturating byte sum;
// the result whose size brings the sum to cfg_wr_data's limit carries
// run_end and clears the sum. The input marked tlast flushes the final group
// with tlast on the output, or sends an end marker (entry_valid clear, all
// fields zero) when nothing survives. While no request is pending and the
// queue has room, the block takes one entry per cycle and the classifier
// pushes one request per cycle into a small queue; a final entry closing a
// surviving group pushes two requests. The back end drains the queue at one
// result per cycle into an output register that holds while the sink
// stalls. Write the run limit (reset 2097152) only while the block is idle.
`include "compaction_dedupe_run_splitter_top_macros.svh"
module compaction_dedupe_run_splitter_top
  import cdrs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wr_en_i,
  input  wire logic [BytesW-1:0]   cfg_wr_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // entry_key, entry_stamp, entry_offset, entry_size, entry_source, zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // entry_deleted
  input  wire logic                s_axis_tuser_i,
  // stream_last
  input  wire logic                s_axis_tlast_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_key, out_offset, out_size, out_source, zero fill
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // entry_valid, run_end
  output logic [OutUserW-1:0]      m_axis_tuser_o,
  // out_last
  output logic                     m_axis_tlast_o
);

  cdrs_push_t push;
  logic       q_full, q_valid, q_pop;
  cdrs_req_t  q_req, out_req;
  logic       out_run_end;

  // Classify each entry against the open group and queue emit requests.
  cdrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_deleted_i (s_axis_tuser_i),
    .s_last_i    (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  // Decouple classification from run splitting.
  cdrs_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_req_o   (q_req),
    .pop_i       (q_pop)
  );

  // Track the byte sum, flag run ends and hold the result for the sink.
  cdrs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .q_valid_i     (q_valid),
    .q_req_i       (q_req),
    .q_pop_o       (q_pop),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_req_o       (out_req),
    .m_run_end_o   (out_run_end)
  );

  assign m_axis_tdata_o = {{(OutDataW - OutUsedW){1'b0}},
                           out_req.source, out_req.size, out_req.offset, out_req.key};
  assign m_axis_tuser_o = {out_run_end, out_req.entry_valid};
  assign m_axis_tlast_o = out_req.last;

  // A request must never arrive at a full queue.
  `CDRS_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push.valid, !q_full)
  // An end marker always ends the stream and never closes a run.
  `CDRS_ASSERT_NOW(a_marker_form, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0],
                   m_axis_tlast_o && !m_axis_tuser_o[1])
  // A queued request reaches an empty output register in the next cycle.
  `CDRS_ASSERT_NEXT(a_drain, clk_i, rst_ni, q_valid && !m_axis_tvalid_o, m_axis_tvalid_o)

endmodule
`default_nettype wire

### design/cdrs_front.sv
`default_nettype none
module cdrs_front
  import cdrs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire logic [InDataW-1:0] s_data_i,
  input  wire logic               s_deleted_i,
  input  wire logic               s_last_i,
  input  wire logic               q_full_i,
  output cdrs_push_t              push_o
);

  logic               group_open_q, group_open_d;
  logic               pend_q, pend_d;
  cdrs_req_t          pend_req_q;
  logic [KeyW-1:0]    group_key_q;
  logic [StampW-1:0]  best_stamp_q;
  logic               best_deleted_q;
  logic [OffsetW-1:0] best_offset_q;
  logic [SizeW-1:0]   best_size_q;
  logic [SourceW-1:0] best_source_q;

  logic [KeyW-1:0]    in_key;
  logic [StampW-1:0]  in_stamp;
  logic [OffsetW-1:0] in_offset;
  logic [SizeW-1:0]   in_size;
  logic [SourceW-1:0] in_source;

  logic      accept, match, take, emit_closed;
  cdrs_req_t req_closed, req_flush;

  assign in_key    = s_data_i[InKeyLsb    +: KeyW];
  assign in_stamp  = s_data_i[InStampLsb  +: StampW];
  assign in_offset = s_data_i[InOffsetLsb +: OffsetW];
  assign in_size   = s_data_i[InSizeLsb   +: SizeW];
  assign in_source = s_data_i[InSourceLsb +: SourceW];

  assign s_ready_o = !pend_q && !q_full_i;
  assign accept    = s_valid_i && s_ready_o;

  assign match       = group_open_q && (in_key == group_key_q);
  assign take        = !match || (in_stamp > best_stamp_q);
  assign emit_closed = !match && group_open_q && !best_deleted_q;

  always_comb begin
    req_closed             = '0;
    req_closed.key         = group_key_q;
    req_closed.offset      = best_offset_q;
    req_closed.size        = best_size_q;
    req_closed.source      = best_source_q;
    req_closed.entry_valid = 1'b1;
    req_closed.last        = 1'b0;

    // Survivor after this item; a tombstone survivor becomes the end marker.
    req_flush      = '0;
    req_flush.last = 1'b1;
    if (take ? !s_deleted_i : !best_deleted_q) begin
      req_flush.key         = take ? in_key : group_key_q;
      req_flush.offset      = take ? in_offset : best_offset_q;
      req_flush.size        = take ? in_size : best_size_q;
      req_flush.source      = take ? in_source : best_source_q;
      req_flush.entry_valid = 1'b1;
    end
  end

  always_comb begin
    push_o       = '0;
    pend_d       = pend_q;
    group_open_d = group_open_q;
    if (pend_q) begin
      push_o.valid = !q_full_i;
      push_o.req   = pend_req_q;
      if (!q_full_i) begin
        pend_d = 1'b0;
      end
    end else if (accept) begin
      push_o.valid = emit_closed || s_last_i;
      push_o.req   = emit_closed ? req_closed : req_flush;
      pend_d       = emit_closed && s_last_i;
      group_open_d = !s_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_open_q <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      group_open_q <= group_open_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_req_q <= req_flush;
      if (take) begin
        group_key_q    <= in_key;
        best_stamp_q   <= in_stamp;
        best_deleted_q <= s_deleted_i;
        best_offset_q  <= in_offset;
        best_size_q    <= in_size;
        best_source_q  <= in_source;
      end
    end
  end

endmodule
`default_nettype wire

### design/cdrs_queue.sv
`default_nettype none
module cdrs_queue
  import cdrs_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cdrs_push_t push_i,
  output logic            full_o,
  output logic            pop_valid_o,
  output cdrs_req_t       pop_req_o,
  input  wire logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cdrs_req_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_req_o   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.req;
    end
  end

endmodule
`default_nettype wire

### design/cdrs_back.sv
`default_nettype none
module cdrs_back
  import cdrs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_wr_en_i,
  input  wire logic [BytesW-1:0] cfg_wr_data_i,
  input  wire logic              q_valid_i,
  input  wire cdrs_req_t         q_req_i,
  output logic                   q_pop_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output cdrs_req_t              m_req_o,
  output logic                   m_run_end_o
);

  logic [BytesW-1:0] limit_q;
  logic [BytesW-1:0] run_bytes_q, run_bytes_d;
  logic              out_valid_q;
  cdrs_req_t         out_req_q;
  logic              run_end_q, run_end_d;
  logic [BytesW:0]   sum_wide;
  logic [BytesW-1:0] sum_sat;

  assign q_pop_o = q_valid_i && (!out_valid_q || m_ready_i);

  // Saturating byte sum; close the run once it reaches the limit.
  assign sum_wide = {1'b0, run_bytes_q} + {{(BytesW + 1 - SizeW){1'b0}}, q_req_i.size};
  assign sum_sat  = sum_wide[BytesW] ? '1 : sum_wide[BytesW-1:0];

  always_comb begin
    run_end_d   = 1'b0;
    run_bytes_d = run_bytes_q;
    if (q_req_i.entry_valid) begin
      run_end_d   = (sum_sat >= limit_q);
      run_bytes_d = (run_end_d || q_req_i.last) ? '0 : sum_sat;
    end else begin
      run_bytes_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= RESET_RUN_LIMIT;
      run_bytes_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
      if (q_pop_o) begin
        run_bytes_q <= run_bytes_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_req_q <= q_req_i;
      run_end_q <= run_end_d;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign m_req_o     = out_req_q;
  assign m_run_end_o = run_end_q;

endmodule
`default_nettype wire
